@@ rtl/core/kvt_pkg.sv @@
// ----------------------------------------------------------------------------
// kvt_pkg
// Shared types and constants of the key/value table core.
// ----------------------------------------------------------------------------
package kvt_pkg;

	localparam int TABLE_DEPTH = 32;
	localparam int IDX_W       = $clog2(TABLE_DEPTH);
	localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

	localparam logic [2:0] FUNC_PUT    = 3'd0;
	localparam logic [2:0] FUNC_GET    = 3'd1;
	localparam logic [2:0] FUNC_DELETE = 3'd2;
	localparam logic [2:0] FUNC_CLEAR  = 3'd3;
	localparam logic [2:0] FUNC_DUMP   = 3'd4;

	localparam logic [1:0] STATUS_OK    = 2'd0;
	localparam logic [1:0] STATUS_MISS  = 2'd1;
	localparam logic [1:0] STATUS_FULL  = 2'd2;

	typedef struct packed {
		logic [2:0]         func;
		logic signed [31:0] item_key;
		logic [31:0]        item_value;
	} req_t;

	typedef struct packed {
		logic signed [31:0] res_key;
		logic [31:0]        res_value;
		logic [1:0]         res_status;
		logic               res_last;
	} rsp_t;

	typedef struct packed {
		logic [31:0] key;
		logic [31:0] value;
	} entry_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_TAIL,
		ST_EXEC,
		ST_DUMP_RD,
		ST_DUMP_OUT
	} state_t;

endpackage

@@ rtl/core/key_value_table_core.sv @@
// ----------------------------------------------------------------------------
// key_value_table_core
// Linear key/value store with put, get, delete, clear and dump requests.
// ----------------------------------------------------------------------------
// One request is taken at a time; req_stall stays high until it is finished.
// Put, get and delete walk the stored entries through the single read port
// of the entry memory, one entry compared per cycle, up to the 32 of a full
// table; delete also reads the tail entry. Clear and an unused func do not
// walk the entries. Dump reads the entries in turn and gives one result per
// entry. A finished result waits in the output register while the next
// request is taken. No clearing pass is run after reset.
// ----------------------------------------------------------------------------
module key_value_table_core (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  kvt_pkg::req_t req_data,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output kvt_pkg::rsp_t rsp_data
);
	import kvt_pkg::*;

	state_t            state_q, state_d;
	req_t              op_q;
	logic [CNT_W-1:0]  count_q;
	logic [CNT_W-1:0]  idx_q;
	logic [CNT_W-1:0]  idx_inc;
	logic [IDX_W-1:0]  cmp_idx_q;
	logic [IDX_W-1:0]  slot_q;
	logic [31:0]       val_q;
	logic              found_q;
	logic              rd_pend_q;
	logic              rsp_valid_q;
	rsp_t              rsp_q;

	entry_t            mem [TABLE_DEPTH];
	entry_t            rd_data_q;

	logic              accept;
	logic              out_free;
	logic              hit;
	logic              more;
	logic              full;
	logic              dump_last;

	logic              rd_en;
	logic [IDX_W-1:0]  rd_addr;
	logic              wr_en;
	logic [IDX_W-1:0]  wr_addr;
	entry_t            wr_data;
	logic              emit;
	rsp_t              emit_data;
	logic              cnt_we;
	logic [CNT_W-1:0]  cnt_d;

	assign accept    = req_valid && !req_stall;
	assign out_free  = !rsp_valid_q || !rsp_stall;
	assign hit       = rd_pend_q && (rd_data_q.key == op_q.item_key);
	assign more      = idx_q < count_q;
	assign full      = count_q == CNT_W'(TABLE_DEPTH);
	assign idx_inc   = idx_q + CNT_W'(1);
	assign dump_last = idx_inc == count_q;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					unique case (req_data.func) inside
						FUNC_PUT, FUNC_GET, FUNC_DELETE: state_d = ST_SEARCH;
						FUNC_CLEAR:                      state_d = ST_EXEC;
						FUNC_DUMP: begin
							state_d = (count_q == '0) ? ST_EXEC : ST_DUMP_RD;
						end
						default:                         state_d = ST_IDLE;
					endcase
				end
			end
			ST_SEARCH: begin
				if (hit) begin
					state_d = (op_q.func == FUNC_DELETE) ? ST_TAIL : ST_EXEC;
				end else if (!more) begin
					state_d = ST_EXEC;
				end
			end
			ST_TAIL:    state_d = ST_EXEC;
			ST_EXEC: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			ST_DUMP_RD: state_d = ST_DUMP_OUT;
			ST_DUMP_OUT: begin
				if (out_free) begin
					state_d = dump_last ? ST_IDLE : ST_DUMP_RD;
				end
			end
			default:    state_d = ST_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		req_stall = 1'b1;
		rd_en     = 1'b0;
		rd_addr   = idx_q[IDX_W-1:0];
		wr_en     = 1'b0;
		wr_addr   = slot_q;
		wr_data   = '{key: op_q.item_key, value: op_q.item_value};
		emit      = 1'b0;
		emit_data = '{res_key: op_q.item_key, res_value: '0,
			res_status: STATUS_OK, res_last: 1'b1};
		cnt_we    = 1'b0;
		cnt_d     = count_q;
		unique case (state_q)
			ST_IDLE:   req_stall = 1'b0;
			ST_SEARCH: rd_en = !hit && more;
			ST_TAIL: begin
				rd_en   = 1'b1;
				rd_addr = IDX_W'(count_q - CNT_W'(1));
			end
			ST_EXEC: begin
				emit = out_free;
				case (op_q.func)
					FUNC_PUT: begin
						if (found_q) begin
							wr_en                = out_free;
							emit_data.res_value  = op_q.item_value;
						end else if (full) begin
							emit_data.res_status = STATUS_FULL;
						end else begin
							wr_en               = out_free;
							wr_addr             = count_q[IDX_W-1:0];
							cnt_we              = out_free;
							cnt_d               = count_q + CNT_W'(1);
							emit_data.res_value = op_q.item_value;
						end
					end
					FUNC_GET: begin
						if (found_q) begin
							emit_data.res_value  = val_q;
						end else begin
							emit_data.res_status = STATUS_MISS;
						end
					end
					FUNC_DELETE: begin
						if (found_q) begin
							// tail entry moves into the freed slot
							wr_en               = out_free;
							wr_data             = rd_data_q;
							cnt_we              = out_free;
							cnt_d               = count_q - CNT_W'(1);
							emit_data.res_value = val_q;
						end else begin
							emit_data.res_status = STATUS_MISS;
						end
					end
					FUNC_CLEAR: begin
						cnt_we            = out_free;
						cnt_d             = '0;
						emit_data.res_key = '0;
					end
					default: begin
						// dump of an empty table
						emit_data.res_key    = '0;
						emit_data.res_status = STATUS_MISS;
					end
				endcase
			end
			ST_DUMP_RD: rd_en = 1'b1;
			ST_DUMP_OUT: begin
				emit      = out_free;
				emit_data = '{res_key: rd_data_q.key, res_value: rd_data_q.value,
					res_status: STATUS_OK, res_last: dump_last};
			end
			default: ;
		endcase
	end

	// entry memory
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			idx_q       <= '0;
			rd_pend_q   <= 1'b0;
			found_q     <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cnt_we) begin
				count_q <= cnt_d;
			end
			if (accept) begin
				idx_q   <= '0;
				found_q <= 1'b0;
			end else if ((state_q == ST_SEARCH && rd_en)
				|| (state_q == ST_DUMP_OUT && emit)) begin
				idx_q <= idx_inc;
			end
			if (state_q == ST_SEARCH && hit) begin
				found_q <= 1'b1;
			end
			rd_pend_q <= (state_q == ST_SEARCH) && rd_en;
			if (emit) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q <= req_data;
		end
		if (rd_en) begin
			cmp_idx_q <= rd_addr;
		end
		if (state_q == ST_SEARCH && hit) begin
			slot_q <= cmp_idx_q;
			val_q  <= rd_data_q.value;
		end
		if (emit) begin
			rsp_q <= emit_data;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp_data  = rsp_q;

`ifndef SYNTHESIS
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(TABLE_DEPTH))
		else $error("entry count beyond table depth");

	// a stored slot, or an append while there is room
	a_write_in_table: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> ({1'b0, wr_addr} < count_q) || (!found_q && !full))
		else $error("write outside stored entries");

	a_dump_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DUMP_OUT && emit) |-> more)
		else $error("dump past last entry");

	a_one_emit_exec: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EXEC && emit) |=> state_q == ST_IDLE)
		else $error("request not retired after its result");
`endif

endmodule

@@ tb/key_value_table_core_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// key_value_table_core_tb
// Self-checking bench for the linear key/value table core. A short table of
// directed requests covers the key extremes, every func code, misses, updates
// and delete with tail move. Random sequences then fill the table past full,
// churn it and drain it. Every response is compared against the bench's shadow
// table or a typed-in expectation, under random valid gaps and response stalls.
// ----------------------------------------------------------------------------
module key_value_table_core_tb;

	import kvt_pkg::*;

	localparam int TOTAL_OPS      = 450;
	localparam int KEY_POOL       = 40;
	localparam int HOLD_OFF       = 400;
	localparam int HOLD_OFF_AT    = 120;
	localparam int DRAIN_CYCLES   = 100;
	localparam int WATCHDOG_LIMIT = 3000;

	typedef struct {
		req_t req;
		bit   fixed;
		rsp_t fixed_rsp;
	} stim_item_t;

	logic  clk;
	logic  arst_n;
	logic  req_valid;
	logic  req_stall;
	req_t  req_data;
	logic  rsp_valid;
	logic  rsp_stall;
	rsp_t  rsp_data;

	stim_item_t  stim_q[$];
	rsp_t        pending_rsp_q[$];
	logic [31:0] key_pool [KEY_POOL];

	// shadow copy of the table
	logic [31:0] shadow_keys   [TABLE_DEPTH];
	logic [31:0] shadow_values [TABLE_DEPTH];
	int          shadow_count;
	int          shadow_peak;

	int  ops_queued;
	int  ops_accepted;
	int  ignored_accepted;
	int  rsp_seen;
	int  full_seen;
	int  miss_seen;
	int  err_count;
	int  idle_cycles;
	bit  stim_done;
	rsp_t want_rsp;

	key_value_table_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req_data  (req_data),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp_data  (rsp_data)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	task automatic add_row(input logic [2:0] f, input logic [31:0] k, input logic [31:0] v,
		input bit fixed = 1'b0, input logic [31:0] ek = '0, input logic [31:0] ev = '0,
		input logic [1:0] es = STATUS_OK);
		stim_item_t it;
		it.req.func              = f;
		it.req.item_key          = k;
		it.req.item_value        = v;
		it.fixed                 = fixed;
		it.fixed_rsp.res_key     = ek;
		it.fixed_rsp.res_value   = ev;
		it.fixed_rsp.res_status  = es;
		it.fixed_rsp.res_last    = 1'b1;
		stim_q.push_back(it);
		if (f <= FUNC_DUMP)
			ops_queued++;
	endtask

	function automatic logic [31:0] pick_key();
		if ($urandom_range(0, 9) == 0)
			return $urandom();
		return key_pool[$urandom_range(0, KEY_POOL - 1)];
	endfunction

	task automatic build_stimulus();
		logic [31:0] order [KEY_POOL];
		logic [31:0] tmp;
		int seg;
		int n;
		int j;
		int r;

		// directed table: expectations typed in where they are obvious
		add_row(FUNC_GET,    32'h0000_0000, 32'h0, 1'b1, 32'h0, 32'h0, STATUS_MISS);
		add_row(FUNC_DUMP,   32'h0000_0000, 32'h0, 1'b1, 32'h0, 32'h0, STATUS_MISS);
		add_row(FUNC_DELETE, 32'h8000_0000, 32'h1, 1'b1, 32'h8000_0000, 32'h0, STATUS_MISS);
		add_row(FUNC_PUT,    32'h8000_0000, 32'h0000_0000);
		add_row(FUNC_PUT,    32'h7FFF_FFFF, 32'hFFFF_FFFF);
		add_row(FUNC_PUT,    32'hFFFF_FFFF, 32'h5555_AAAA);
		add_row(FUNC_PUT,    32'h0000_0000, 32'hAAAA_5555);
		add_row(FUNC_GET,    32'h7FFF_FFFF, 32'h0);
		add_row(FUNC_PUT,    32'h7FFF_FFFF, 32'h0000_0000);
		add_row(FUNC_GET,    32'h7FFF_FFFF, 32'hFFFF_FFFF);
		add_row(FUNC_DUMP,   32'h0,         32'h0);
		add_row(FUNC_DELETE, 32'h8000_0000, 32'h0);
		add_row(FUNC_GET,    32'h0000_0000, 32'h0);
		add_row(FUNC_DELETE, 32'h0000_0000, 32'h0);
		add_row(FUNC_GET,    32'h8000_0000, 32'h0, 1'b1, 32'h8000_0000, 32'h0, STATUS_MISS);
		add_row(3'd5,        32'h1234_5678, 32'h1);
		add_row(3'd6,        32'hFFFF_FFFF, 32'hFFFF_FFFF);
		add_row(3'd7,        32'h0,         32'h0);
		add_row(FUNC_DUMP,   32'h0,         32'h0);
		add_row(FUNC_DELETE, 32'h7FFF_FFFF, 32'h0);
		add_row(FUNC_DELETE, 32'hFFFF_FFFF, 32'h0);
		add_row(FUNC_DUMP,   32'h0,         32'h0, 1'b1, 32'h0, 32'h0, STATUS_MISS);
		add_row(FUNC_PUT,    32'h1234_5678, 32'h1);
		add_row(FUNC_CLEAR,  32'hDEAD_BEEF, 32'h0, 1'b1, 32'h0, 32'h0, STATUS_OK);
		add_row(FUNC_GET,    32'h1234_5678, 32'h0, 1'b1, 32'h1234_5678, 32'h0, STATUS_MISS);

		key_pool[0] = 32'h8000_0000;
		key_pool[1] = 32'h7FFF_FFFF;
		key_pool[2] = 32'h0000_0000;
		key_pool[3] = 32'hFFFF_FFFF;
		for (int i = 4; i < KEY_POOL; i++)
			key_pool[i] = $urandom();

		while (ops_queued < TOTAL_OPS) begin
			seg = $urandom_range(0, 99);
			if (seg < 25) begin
				// fill past full: more distinct keys than the table holds
				if ($urandom_range(0, 1))
					add_row(FUNC_CLEAR, $urandom(), $urandom());
				order = key_pool;
				for (j = KEY_POOL - 1; j > 0; j--) begin
					n = $urandom_range(0, j);
					tmp = order[j];
					order[j] = order[n];
					order[n] = tmp;
				end
				for (j = 0; j < KEY_POOL; j++) begin
					add_row(FUNC_PUT, order[j], $urandom());
					if ($urandom_range(0, 4) == 0)
						add_row(FUNC_GET, pick_key(), $urandom());
				end
				add_row(FUNC_DUMP, $urandom(), $urandom());
			end else if (seg < 75) begin
				for (j = 0; j < 30; j++) begin
					r = $urandom_range(0, 99);
					if (r < 4)
						add_row(3'($urandom_range(5, 7)), $urandom(), $urandom());
					else if (r < 40)
						add_row(FUNC_PUT, pick_key(), $urandom());
					else if (r < 64)
						add_row(FUNC_GET, pick_key(), $urandom());
					else if (r < 88)
						add_row(FUNC_DELETE, pick_key(), $urandom());
					else if (r < 96)
						add_row(FUNC_DUMP, $urandom(), $urandom());
					else
						add_row(FUNC_CLEAR, $urandom(), $urandom());
				end
			end else begin
				// drain mostly by delete
				for (j = 0; j < 25; j++) begin
					r = $urandom_range(0, 99);
					if (r < 60)
						add_row(FUNC_DELETE, pick_key(), $urandom());
					else if (r < 85)
						add_row(FUNC_GET, pick_key(), $urandom());
					else if (r < 95)
						add_row(FUNC_PUT, pick_key(), $urandom());
					else
						add_row(FUNC_DUMP, $urandom(), $urandom());
				end
				add_row(FUNC_DUMP, $urandom(), $urandom());
			end
		end
	endtask

	function automatic int shadow_find(input logic [31:0] k);
		for (int i = 0; i < shadow_count; i++)
			if (shadow_keys[i] == k)
				return i;
		return -1;
	endfunction

	// update the shadow table and queue the responses this request should give
	task automatic predict_request(input stim_item_t it);
		int slot;
		rsp_t r;
		rsp_t outs[$];
		slot = shadow_find(it.req.item_key);
		r.res_key    = it.req.item_key;
		r.res_value  = '0;
		r.res_status = STATUS_OK;
		r.res_last   = 1'b1;
		case (it.req.func)
			FUNC_PUT: begin
				if (slot >= 0) begin
					shadow_values[slot] = it.req.item_value;
					r.res_value = it.req.item_value;
				end else if (shadow_count >= TABLE_DEPTH) begin
					r.res_status = STATUS_FULL;
				end else begin
					shadow_keys[shadow_count]   = it.req.item_key;
					shadow_values[shadow_count] = it.req.item_value;
					shadow_count++;
					r.res_value = it.req.item_value;
				end
				outs.push_back(r);
			end
			FUNC_GET: begin
				if (slot >= 0)
					r.res_value = shadow_values[slot];
				else
					r.res_status = STATUS_MISS;
				outs.push_back(r);
			end
			FUNC_DELETE: begin
				if (slot >= 0) begin
					r.res_value = shadow_values[slot];
					shadow_keys[slot]   = shadow_keys[shadow_count - 1];
					shadow_values[slot] = shadow_values[shadow_count - 1];
					shadow_count--;
				end else begin
					r.res_status = STATUS_MISS;
				end
				outs.push_back(r);
			end
			FUNC_CLEAR: begin
				shadow_count = 0;
				r.res_key = '0;
				outs.push_back(r);
			end
			FUNC_DUMP: begin
				if (shadow_count == 0) begin
					r.res_key    = '0;
					r.res_status = STATUS_MISS;
					outs.push_back(r);
				end else begin
					for (int i = 0; i < shadow_count; i++) begin
						r.res_key   = shadow_keys[i];
						r.res_value = shadow_values[i];
						r.res_last  = (i == shadow_count - 1);
						outs.push_back(r);
					end
				end
			end
			default: ;
		endcase
		if (shadow_count > shadow_peak)
			shadow_peak = shadow_count;
		if (it.fixed && outs.size() != 0)
			pending_rsp_q.push_back(it.fixed_rsp);
		else
			foreach (outs[i])
				pending_rsp_q.push_back(outs[i]);
	endtask

	task automatic check_field(input string name, input logic [31:0] want,
		input logic [31:0] got);
		if (got !== want) begin
			$error("%s mismatch: expected 0x%08h, got 0x%08h", name, want, got);
			err_count++;
		end
	endtask

	// request driver: bursts of random length, random gaps between them
	initial begin : req_driver
		stim_item_t it;
		int burst_left;
		int gap;
		req_valid = 1'b0;
		req_data  = '0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		burst_left = $urandom_range(1, 10);
		while (stim_q.size() != 0) begin
			it = stim_q.pop_front();
			req_data  <= it.req;
			req_valid <= 1'b1;
			do
				@(posedge clk);
			while (req_stall);
			predict_request(it);
			if (it.req.func <= FUNC_DUMP)
				ops_accepted++;
			else
				ignored_accepted++;
			burst_left--;
			if (burst_left == 0 && stim_q.size() != 0) begin
				burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
					: $urandom_range(1, 10);
				gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
				if (gap > 0) begin
					req_valid <= 1'b0;
					repeat (gap) @(posedge clk);
				end
			end
		end
		req_valid <= 1'b0;
		stim_done = 1'b1;
	end

	// response stall pattern, with one long hold-off to back the core up
	initial begin : rsp_stall_gen
		int seg_left;
		int stall_mode;
		bit held_off;
		rsp_stall  = 1'b0;
		seg_left   = 0;
		stall_mode = 0;
		held_off   = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (!held_off && rsp_seen >= HOLD_OFF_AT) begin
				held_off = 1'b1;
				rsp_stall <= 1'b1;
				repeat (HOLD_OFF) @(posedge clk);
			end else begin
				if (seg_left == 0) begin
					seg_left   = $urandom_range(8, 64);
					stall_mode = $urandom_range(0, 3);
				end
				seg_left--;
				case (stall_mode)
					0: rsp_stall <= 1'b0;
					1: rsp_stall <= ($urandom_range(0, 3) == 0);
					2: rsp_stall <= ($urandom_range(0, 1) == 0);
					default: rsp_stall <= ($urandom_range(0, 3) != 0);
				endcase
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n === 1'b1 && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
			rsp_seen++;
			if (pending_rsp_q.size() == 0) begin
				$error("response with nothing pending: key 0x%08h status %0d",
					rsp_data.res_key, rsp_data.res_status);
				err_count++;
			end else begin
				want_rsp = pending_rsp_q.pop_front();
				check_field("res_key", want_rsp.res_key, rsp_data.res_key);
				check_field("res_value", want_rsp.res_value, rsp_data.res_value);
				check_field("res_status", 32'(want_rsp.res_status), 32'(rsp_data.res_status));
				check_field("res_last", 32'(want_rsp.res_last), 32'(rsp_data.res_last));
			end
			if (rsp_data.res_status == STATUS_FULL)
				full_seen++;
			if (rsp_data.res_status == STATUS_MISS)
				miss_seen++;
		end
	end

	// watchdog on cycles where neither side moves anything
	always @(posedge clk) begin
		if ((req_valid === 1'b1 && req_stall === 1'b0)
			|| (rsp_valid === 1'b1 && rsp_stall === 1'b0))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: no handshake for %0d cycles, %0d responses pending",
				idle_cycles, pending_rsp_q.size());
			$display("tb: failure");
			$finish;
		end
	end

	initial begin : run_control
		arst_n = 1'b0;
		build_stimulus();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		wait (stim_done);
		while (pending_rsp_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("summary: %0d requests (%0d more with unused codes), %0d responses checked",
			ops_accepted, ignored_accepted, rsp_seen);
		$display("summary: %0d table-full and %0d miss responses, peak occupancy %0d of %0d",
			full_seen, miss_seen, shadow_peak, TABLE_DEPTH);
		if (err_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
